// ===== hdl/eprrs_pkg.sv =====
// Shared types and constants of the egress priority round-robin scheduler.
// Holds the request and status codes and the default sizes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package eprrs_pkg;

   localparam int PORTS_DEFAULT       = 8;
   localparam int QUEUES_DEFAULT      = 8;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam int PORT_FIELD_W  = 3;
   localparam int QUEUE_FIELD_W = 3;
   localparam int CSR_W         = 4;

   localparam logic [CSR_W-1:0] PORTS_IN_USE_RESET = 4'd8;

   typedef enum logic {
      REQ_ENQUEUE = 1'b0,
      REQ_TX_END  = 1'b1
   } req_code_type;

   typedef enum logic [1:0] {
      ST_NONE  = 2'd0,
      ST_GRANT = 2'd1,
      ST_FULL  = 2'd2,
      ST_DROP  = 2'd3
   } status_type;

endpackage

`default_nettype wire

// ===== hdl/eprrs_count_bank.sv =====
// Bank of per-port, per-queue packet counters, one counter cell per queue.
// Each cell reports whether it is empty or full; no package items are used.
// Driven by one-hot increment and decrement vectors from the top level.
`timescale 1ns / 1ps
`default_nettype none

module eprrs_count_bank #(
   parameter int CELLS       = 64,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CELLS-1:0] inc_vec,
   input  wire logic [CELLS-1:0] dec_vec,
   output logic      [CELLS-1:0] nonempty_vec,
   output logic      [CELLS-1:0] full_vec
);

   logic [COUNT_WIDTH-1:0] count_ff [CELLS];
   logic [COUNT_WIDTH-1:0] count_in [CELLS];

   always_comb begin
      for (int i = 0; i < CELLS; i++) begin
         count_in[i] = count_ff[i];
         if (inc_vec[i] && !dec_vec[i]) begin
            count_in[i] = count_ff[i] + COUNT_WIDTH'(1);
         end else if (dec_vec[i] && !inc_vec[i]) begin
            count_in[i] = count_ff[i] - COUNT_WIDTH'(1);
         end
         nonempty_vec[i] = |count_ff[i];
         full_vec[i]     = &count_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CELLS; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/eprrs_rr_pick.sv =====
// Queue selection for one port: strict priority for the top queue, then a
// rotating priority encoder over the other queues starting at the pointer.
// Purely combinational; no package items are used.
`timescale 1ns / 1ps
`default_nettype none

module eprrs_rr_pick #(
   parameter int QUEUES = 8
) (
   input  wire logic [QUEUES-1:0]         row,
   input  wire logic [$clog2(QUEUES)-1:0] ptr,
   output logic                           found,
   output logic                           rr_grant,
   output logic      [$clog2(QUEUES)-1:0] sel,
   output logic      [$clog2(QUEUES)-1:0] next_ptr
);

   localparam int QW = $clog2(QUEUES);
   localparam int RR = QUEUES - 1;

   logic [RR-1:0] rr_row;
   logic [RR-1:0] hi_row;
   logic          hi_found;
   logic          lo_found;
   logic [QW-1:0] hi_sel;
   logic [QW-1:0] lo_sel;

   always_comb begin
      rr_row   = row[RR-1:0];
      hi_found = 1'b0;
      lo_found = 1'b0;
      hi_sel   = '0;
      lo_sel   = '0;
      for (int i = RR - 1; i >= 0; i--) begin
         hi_row[i] = rr_row[i] && (QW'(i) >= ptr);
         if (hi_row[i]) begin
            hi_found = 1'b1;
            hi_sel   = QW'(i);
         end
         if (rr_row[i]) begin
            lo_found = 1'b1;
            lo_sel   = QW'(i);
         end
      end

      if (row[RR]) begin
         found    = 1'b1;
         rr_grant = 1'b0;
         sel      = QW'(RR);
      end else begin
         found    = lo_found;
         rr_grant = lo_found;
         sel      = hi_found ? hi_sel : lo_sel;
      end

      if (sel == QW'(RR - 1)) begin
         next_ptr = '0;
      end else begin
         next_ptr = sel + QW'(1);
      end
   end

endmodule

`default_nettype wire

// ===== hdl/egress_priority_round_robin_scheduler.sv =====
// Top level of the egress priority round-robin scheduler.
// Uses eprrs_pkg, eprrs_count_bank and eprrs_rr_pick.
//
// An item is an enqueue or a transmit-end event for one egress port, and each
// item yields exactly one result item: no grant, a grant, a rejected enqueue
// or a grant dropped on an absent port. The block takes one item per clock
// cycle while no result item is stalled: the item is held in an input
// register, the counter cells, busy flags and pointers are updated as it
// leaves that register, and the result is presented from an output
// register. While a result item is stalled the input register holds its item,
// so the input stalls once both registers are full.
// All packet counters are flip-flop cells cleared by reset, so the block is
// ready right after reset. The user must write the ports_in_use register
// through the csr channel while the block is idle; it is not enforced.
`timescale 1ns / 1ps
`default_nettype none

module egress_priority_round_robin_scheduler #(
   parameter int PORTS       = eprrs_pkg::PORTS_DEFAULT,
   parameter int QUEUES      = eprrs_pkg::QUEUES_DEFAULT,
   parameter int COUNT_WIDTH = eprrs_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_type,
   input  wire logic [eprrs_pkg::PORT_FIELD_W-1:0]  req_port,
   input  wire logic [eprrs_pkg::QUEUE_FIELD_W-1:0] req_queue,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [1:0]                          rsp_status,
   output logic      [eprrs_pkg::PORT_FIELD_W-1:0]  rsp_grant_port,
   output logic      [eprrs_pkg::QUEUE_FIELD_W-1:0] rsp_grant_queue,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [eprrs_pkg::CSR_W-1:0]         csr_data
);

   localparam int CELLS  = PORTS * QUEUES;
   localparam int CELL_W = $clog2(CELLS);
   localparam int QW     = $clog2(QUEUES);
   localparam int PW     = (PORTS > 1) ? $clog2(PORTS) : 1;
   localparam int PF     = eprrs_pkg::PORT_FIELD_W;
   localparam int QF     = eprrs_pkg::QUEUE_FIELD_W;

   logic                      in_valid_ff, in_valid_in;
   logic                      req_type_ff, req_type_in;
   logic [PF-1:0]             port_ff, port_in;
   logic [QF-1:0]             queue_ff, queue_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   eprrs_pkg::status_type     status_ff, status_in;
   logic [PF-1:0]             gport_ff, gport_in;
   logic [QF-1:0]             gqueue_ff, gqueue_in;
   logic [PORTS-1:0]          busy_ff, busy_in;
   logic [QW-1:0]             ptr_ff [PORTS];
   logic [QW-1:0]             ptr_in [PORTS];
   logic [eprrs_pkg::CSR_W-1:0] piu_ff, piu_in;

   logic                      in_ready;
   logic                      fire;
   logic                      port_ok;
   logic                      queue_ok;
   logic                      is_enqueue;
   logic                      try_grant;
   logic [PW-1:0]             pidx;
   logic [QW-1:0]             qidx;
   logic [CELL_W-1:0]         row_base;
   logic [CELL_W-1:0]         enq_cell;
   logic [CELL_W-1:0]         deq_cell;
   logic [QUEUES-1:0]         row;
   logic [QUEUES-1:0]         pick_row;
   logic                      inc_en;
   logic                      dec_en;
   logic [CELLS-1:0]          inc_vec;
   logic [CELLS-1:0]          dec_vec;
   logic [CELLS-1:0]          nonempty_vec;
   logic [CELLS-1:0]          full_vec;
   logic                      pick_found;
   logic                      pick_rr;
   logic [QW-1:0]             pick_sel;
   logic [QW-1:0]             pick_next;

   assign fire      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign in_ready  = !in_valid_ff || fire;
   assign req_stall = !in_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_grant_port  = gport_ff;
   assign rsp_grant_queue = gqueue_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      req_type_in = req_type_ff;
      port_in     = port_ff;
      queue_in    = queue_ff;
      if (req_valid && in_ready) begin
         in_valid_in = 1'b1;
         req_type_in = req_type;
         port_in     = req_port;
         queue_in    = req_queue;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);
      piu_in       = csr_valid ? csr_data : piu_ff;
   end

   always_comb begin
      port_ok    = 32'(port_ff) < PORTS;
      queue_ok   = 32'(queue_ff) < QUEUES;
      is_enqueue = req_type_ff == eprrs_pkg::REQ_ENQUEUE;
      pidx       = port_ok ? PW'(port_ff) : '0;
      qidx       = queue_ok ? QW'(queue_ff) : '0;
      row_base   = CELL_W'(32'(pidx) * QUEUES);
      enq_cell   = CELL_W'(32'(pidx) * QUEUES + 32'(qidx));
      deq_cell   = CELL_W'(32'(pidx) * QUEUES + 32'(pick_sel));
      row        = nonempty_vec[row_base +: QUEUES];
      pick_row   = is_enqueue ? (row | (QUEUES'(1) << qidx)) : row;
   end

   eprrs_rr_pick #(
      .QUEUES(QUEUES)
   ) u_pick (
      .row      (pick_row),
      .ptr      (ptr_ff[pidx]),
      .found    (pick_found),
      .rr_grant (pick_rr),
      .sel      (pick_sel),
      .next_ptr (pick_next)
   );

   always_comb begin
      status_in = status_ff;
      gport_in  = gport_ff;
      gqueue_in = gqueue_ff;
      busy_in   = busy_ff;
      ptr_in    = ptr_ff;
      inc_en    = 1'b0;
      dec_en    = 1'b0;
      try_grant = 1'b0;
      if (fire) begin
         status_in = eprrs_pkg::ST_NONE;
         gport_in  = '0;
         gqueue_in = '0;
         if (port_ok) begin
            if (is_enqueue) begin
               if (queue_ok) begin
                  if (full_vec[enq_cell]) begin
                     status_in = eprrs_pkg::ST_FULL;
                  end else begin
                     inc_en    = 1'b1;
                     try_grant = !busy_ff[pidx];
                  end
               end
            end else begin
               busy_in[pidx] = 1'b0;
               try_grant     = 1'b1;
            end
            if (try_grant && pick_found) begin
               dec_en    = 1'b1;
               gport_in  = port_ff;
               gqueue_in = QF'(pick_sel);
               if (pick_rr) begin
                  ptr_in[pidx] = pick_next;
               end
               if ({1'b0, port_ff} >= piu_ff) begin
                  status_in = eprrs_pkg::ST_DROP;
               end else begin
                  status_in     = eprrs_pkg::ST_GRANT;
                  busy_in[pidx] = 1'b1;
               end
            end
         end
      end
      inc_vec = inc_en ? (CELLS'(1) << enq_cell) : '0;
      dec_vec = dec_en ? (CELLS'(1) << deq_cell) : '0;
   end

   eprrs_count_bank #(
      .CELLS       (CELLS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_counts (
      .clock        (clock),
      .reset        (reset),
      .inc_vec      (inc_vec),
      .dec_vec      (dec_vec),
      .nonempty_vec (nonempty_vec),
      .full_vec     (full_vec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         busy_ff      <= '0;
         piu_ff       <= eprrs_pkg::PORTS_IN_USE_RESET;
         for (int i = 0; i < PORTS; i++) begin
            ptr_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         busy_ff      <= busy_in;
         piu_ff       <= piu_in;
         ptr_ff       <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff <= req_type_in;
      port_ff     <= port_in;
      queue_ff    <= queue_in;
      status_ff   <= status_in;
      gport_ff    <= gport_in;
      gqueue_ff   <= gqueue_in;
   end

endmodule

`default_nettype wire

// ===== test/eprrs_grant_checker.sv =====
// Grant checker for the egress priority round-robin scheduler testbench.
// Watches the request, result and csr channels, predicts every result item and compares.
// Depends on eprrs_pkg for the request and status codes.
`timescale 1ns / 1ps

module eprrs_grant_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_type,
   input  logic [eprrs_pkg::PORT_FIELD_W-1:0]  req_port,
   input  logic [eprrs_pkg::QUEUE_FIELD_W-1:0] req_queue,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [1:0]                          rsp_status,
   input  logic [eprrs_pkg::PORT_FIELD_W-1:0]  rsp_grant_port,
   input  logic [eprrs_pkg::QUEUE_FIELD_W-1:0] rsp_grant_queue,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [eprrs_pkg::CSR_W-1:0]         csr_data,
   output int                                  mismatch_total,
   output int                                  open_results
);

   localparam int PORTS       = eprrs_pkg::PORTS_DEFAULT;
   localparam int QUEUES      = eprrs_pkg::QUEUES_DEFAULT;
   localparam int COUNT_WIDTH = eprrs_pkg::COUNT_WIDTH_DEFAULT;
   localparam int PF          = eprrs_pkg::PORT_FIELD_W;
   localparam int QF          = eprrs_pkg::QUEUE_FIELD_W;
   localparam int TOP_QUEUE   = QUEUES - 1;
   localparam int RR_QUEUES   = QUEUES - 1;

   typedef struct {
      eprrs_pkg::status_type status;
      logic [PF-1:0]         port;
      logic [QF-1:0]         queue;
   } grant_item_type;

   grant_item_type                expected_grants[$];
   logic [COUNT_WIDTH-1:0]        pkt_count [PORTS*QUEUES];
   bit                            port_busy [PORTS];
   int unsigned                   rr_next [PORTS];
   logic [eprrs_pkg::CSR_W-1:0]   ports_attached;

   function automatic grant_item_type idle_item();
      grant_item_type r;
      r.status = eprrs_pkg::ST_NONE;
      r.port   = '0;
      r.queue  = '0;
      return r;
   endfunction

   // Strict priority on the top queue, round robin over the rest from the pointer.
   function automatic grant_item_type try_dequeue(input int unsigned p);
      grant_item_type r;
      int unsigned base;
      int unsigned sel;
      int unsigned start;
      bit found;
      base  = p * QUEUES;
      sel   = 0;
      found = 1'b0;
      r     = idle_item();
      if (pkt_count[base + TOP_QUEUE] != 0) begin
         sel   = TOP_QUEUE;
         found = 1'b1;
      end else begin
         start = rr_next[p] % RR_QUEUES;
         for (int i = 0; i < RR_QUEUES; i++) begin
            int unsigned q;
            q = (start + i) % RR_QUEUES;
            if (!found && pkt_count[base + q] != 0) begin
               sel   = q;
               found = 1'b1;
            end
         end
         if (found) begin
            rr_next[p] = (sel + 1) % RR_QUEUES;
         end
      end
      if (!found) begin
         return r;
      end
      pkt_count[base + sel] = pkt_count[base + sel] - 1'b1;
      r.port  = p[PF-1:0];
      r.queue = sel[QF-1:0];
      if (p >= int'(ports_attached)) begin
         r.status = eprrs_pkg::ST_DROP;
      end else begin
         port_busy[p] = 1'b1;
         r.status     = eprrs_pkg::ST_GRANT;
      end
      return r;
   endfunction

   function automatic grant_item_type schedule_event(input eprrs_pkg::req_code_type kind,
                                                     input int unsigned p,
                                                     input int unsigned q);
      grant_item_type r;
      int unsigned idx;
      r = idle_item();
      if (p >= PORTS) begin
         return r;
      end
      if (kind == eprrs_pkg::REQ_TX_END) begin
         port_busy[p] = 1'b0;
         return try_dequeue(p);
      end
      if (q >= QUEUES) begin
         return r;
      end
      idx = p * QUEUES + q;
      if (pkt_count[idx] == {COUNT_WIDTH{1'b1}}) begin
         r.status = eprrs_pkg::ST_FULL;
         return r;
      end
      pkt_count[idx] = pkt_count[idx] + 1'b1;
      if (port_busy[p]) begin
         return r;
      end
      return try_dequeue(p);
   endfunction

   always @(posedge clock) begin
      grant_item_type want;
      grant_item_type pred;
      if (reset) begin
         foreach (pkt_count[i]) pkt_count[i] = '0;
         foreach (port_busy[i]) port_busy[i] = 1'b0;
         foreach (rr_next[i]) rr_next[i] = 0;
         ports_attached = eprrs_pkg::PORTS_IN_USE_RESET;
         expected_grants.delete();
         mismatch_total = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            ports_attached = csr_data;
         end
         if (req_valid && !req_stall) begin
            pred = schedule_event(eprrs_pkg::req_code_type'(req_type),
                                  req_port, req_queue);
            expected_grants = {expected_grants, pred};
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_grants.size() == 0) begin
               if (mismatch_total < 10) begin
                  $display("unexpected result item: status %0d port %0d queue %0d",
                           rsp_status, rsp_grant_port, rsp_grant_queue);
               end
               mismatch_total++;
            end else begin
               want = expected_grants.pop_front();
               if (rsp_status !== want.status || rsp_grant_port !== want.port ||
                   rsp_grant_queue !== want.queue) begin
                  if (mismatch_total < 10) begin
                     $display({"mismatch: expected status %0d port %0d queue %0d, ",
                               "got status %0d port %0d queue %0d"},
                              want.status, want.port, want.queue,
                              rsp_status, rsp_grant_port, rsp_grant_queue);
                  end
                  mismatch_total++;
               end
            end
         end
      end
      open_results = expected_grants.size();
   end

endmodule

// ===== test/tb_egress_priority_round_robin_scheduler.sv =====
// Testbench top for the egress priority round-robin scheduler.
// Drives directed and random events and csr writes; uses eprrs_pkg and eprrs_grant_checker.
// The checker predicts and compares, this module gives the verdict.
`timescale 1ns / 1ps

module tb_egress_priority_round_robin_scheduler;

   localparam int PF           = eprrs_pkg::PORT_FIELD_W;
   localparam int QF           = eprrs_pkg::QUEUE_FIELD_W;
   localparam int CW           = eprrs_pkg::CSR_W;
   localparam int BLOCK_ITEMS  = 320;
   localparam int HOLD_CYCLES  = 400;
   localparam int FILL_ITEMS   = 32;
   localparam logic [CW-1:0] CFG_PLAN [6] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd5, 4'd3};

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_type = eprrs_pkg::REQ_ENQUEUE;
   logic [PF-1:0]            req_port = '0;
   logic [QF-1:0]            req_queue = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [1:0]               rsp_status;
   logic [PF-1:0]            rsp_grant_port;
   logic [QF-1:0]            rsp_grant_queue;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CW-1:0]            csr_data = '0;

   int mismatch_total;
   int open_results;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int hold_served = 0;
   logic [PF-1:0] focus_port = '0;

   egress_priority_round_robin_scheduler uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_port        (req_port),
      .req_queue       (req_queue),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_grant_port  (rsp_grant_port),
      .rsp_grant_queue (rsp_grant_queue),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   eprrs_grant_checker check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_port        (req_port),
      .req_queue       (req_queue),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_grant_port  (rsp_grant_port),
      .rsp_grant_queue (rsp_grant_queue),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .mismatch_total  (mismatch_total),
      .open_results    (open_results)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random, or holds off for a long stretch on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   task automatic offer_event(input eprrs_pkg::req_code_type kind,
                              input logic [PF-1:0] port,
                              input logic [QF-1:0] queue);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= kind;
      req_port  <= port;
      req_queue <= queue;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic offer_random_event();
      eprrs_pkg::req_code_type kind;
      logic [PF-1:0]           port;
      logic [QF-1:0]           queue;
      kind = ($urandom_range(99) < 58) ? eprrs_pkg::REQ_ENQUEUE : eprrs_pkg::REQ_TX_END;
      if ($urandom_range(99) < 60) begin
         port = focus_port;
      end else begin
         port = $urandom_range(7);
      end
      if ($urandom_range(7) == 0) begin
         queue = 3'd7;
      end else begin
         queue = $urandom_range(7);
      end
      offer_event(kind, port, queue);
   endtask

   // Lowers valid and waits until every expected result item has arrived.
   task automatic results_settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (open_results != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_ports_in_use(input logic [CW-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 29;
      recv_idle_pct = 48;
      offer_event(eprrs_pkg::REQ_TX_END, 3'd0, 3'd0);
      offer_event(eprrs_pkg::REQ_ENQUEUE, 3'd0, 3'd0);
      offer_event(eprrs_pkg::REQ_ENQUEUE, 3'd0, 3'd7);
      offer_event(eprrs_pkg::REQ_ENQUEUE, 3'd0, 3'd3);
      offer_event(eprrs_pkg::REQ_ENQUEUE, 3'd0, 3'd0);
      repeat (4) offer_event(eprrs_pkg::REQ_TX_END, 3'd0, 3'd0);
      offer_event(eprrs_pkg::REQ_ENQUEUE, 3'd7, 3'd6);
      offer_event(eprrs_pkg::REQ_ENQUEUE, 3'd7, 3'd0);
      offer_event(eprrs_pkg::REQ_TX_END, 3'd7, 3'd0);
      results_settle();
      write_ports_in_use(4'd4);
      offer_event(eprrs_pkg::REQ_ENQUEUE, 3'd5, 3'd2);
      offer_event(eprrs_pkg::REQ_ENQUEUE, 3'd5, 3'd7);
      offer_event(eprrs_pkg::REQ_ENQUEUE, 3'd3, 3'd1);
      results_settle();
      write_ports_in_use(4'd0);
      offer_event(eprrs_pkg::REQ_ENQUEUE, 3'd0, 3'd5);
      offer_event(eprrs_pkg::REQ_TX_END, 3'd3, 3'd0);
      results_settle();
      write_ports_in_use(4'd15);
      offer_event(eprrs_pkg::REQ_ENQUEUE, 3'd7, 3'd7);
      offer_event(eprrs_pkg::REQ_TX_END, 3'd7, 3'd0);

      for (int m = 0; m < 3; m++) begin
         send_idle_pct = (m == 0) ? 29 : (m == 1) ? 48 : 0;
         recv_idle_pct = (m == 0) ? 48 : (m == 1) ? 29 : 0;
         for (int b = 0; b < 2; b++) begin
            results_settle();
            write_ports_in_use(CFG_PLAN[m*2 + b]);
            for (int k = 0; k < BLOCK_ITEMS; k++) begin
               if (k % 16 == 0) focus_port = $urandom_range(7);
               if (m == 0 && b == 0 && k == 120) hold_requests++;
               if (m == 1 && b == 1 && k == 160) results_settle();
               offer_random_event();
            end
         end
      end

      // Keep port 6 busy and let one of its queues build up a backlog.
      results_settle();
      write_ports_in_use(4'd8);
      offer_event(eprrs_pkg::REQ_ENQUEUE, 3'd6, 3'd1);
      repeat (FILL_ITEMS) offer_event(eprrs_pkg::REQ_ENQUEUE, 3'd6, 3'd2);
      repeat (3) offer_event(eprrs_pkg::REQ_TX_END, 3'd6, 3'd0);

      req_valid <= 1'b0;
      for (int n = 0; n < 20000 && open_results != 0; n++) @(negedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
      if (mismatch_total == 0 && open_results == 0) begin
         $display("egress_priority_round_robin_scheduler test passed");
      end else begin
         $display("egress_priority_round_robin_scheduler test failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("egress_priority_round_robin_scheduler test failed");
      $finish;
   end

endmodule
